// ----- rtl/core/dtfp_pkg.sv -----
package dtfp_pkg;

	// ascii characters of the number grammar
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_MALFORMED = 2'd1;
	localparam status_t ST_SATURATED = 2'd2;

	// fraction scale table: entry k is floor(2^facc / 10^(k+1)), the last entry is 0 when FRAC_BITS is at most 35
	localparam int SCALE_N = 13;
	localparam int IDX_W   = 4;
	typedef logic [IDX_W-1:0] scale_idx_t;

endpackage

// ----- rtl/core/dtfp_parse.sv -----
module dtfp_parse #(
	parameter int INT_BITS  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [7:0]                       text_byte,
	output logic                             res_fire,
	output logic [INT_BITS+FRAC_BITS:0]      res_value,
	output dtfp_pkg::status_t                res_status
);
	import dtfp_pkg::*;

	localparam int FACC_BITS = FRAC_BITS + 8;
	localparam int MAG_BITS  = INT_BITS + FRAC_BITS;
	localparam int OUT_BITS  = MAG_BITS + 1;
	localparam int IW_BITS   = INT_BITS + 4;
	localparam logic [IW_BITS-1:0] INT_MAX_W = {4'd0, {INT_BITS{1'b1}}};

	localparam logic [2:0] PH_START      = 3'd0;
	localparam logic [2:0] PH_AFTER_SIGN = 3'd1;
	localparam logic [2:0] PH_INT        = 3'd2;
	localparam logic [2:0] PH_FRAC       = 3'd3;
	localparam logic [2:0] PH_BAD        = 3'd4;

	logic [FACC_BITS-1:0] scale_tab [SCALE_N];

	genvar k;
	for (k = 0; k < SCALE_N; k++) begin : g_scale
		localparam logic [63:0] SCALE_K = (64'd1 << FACC_BITS) / (64'd10 ** (k + 1));
		assign scale_tab[k] = SCALE_K[FACC_BITS-1:0];
	end

	logic [2:0]           phase_q, phase_d;
	logic                 neg_q, neg_d;
	logic [INT_BITS-1:0]  int_q, int_d;
	logic                 ovf_q, ovf_d;
	logic [FACC_BITS-1:0] facc_q, facc_d;
	scale_idx_t           idx_q, idx_d;

	logic                   is_digit;
	logic [3:0]             digit;
	logic [IW_BITS-1:0]     int_wide;
	logic                   int_sat;
	logic [FACC_BITS+3:0]   frac_term;
	logic [MAG_BITS-1:0]    mag;
	logic [OUT_BITS-1:0]    value_pos;

	always_comb begin
		is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		// '0'..'9' are 0x30..0x39, so the low nibble is the digit value
		digit = text_byte[3:0];
		int_wide = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + {{(IW_BITS-4){1'b0}}, digit};
		int_sat = int_wide > INT_MAX_W;
		frac_term = {4'd0, scale_tab[idx_q]} * {{FACC_BITS{1'b0}}, digit};
	end

	// result for the terminating byte
	always_comb begin
		mag = {int_q, facc_q[FACC_BITS-1:8]};
		res_status = ST_OK;
		if (phase_q != PH_INT && phase_q != PH_FRAC) begin
			mag = '0;
			res_status = ST_MALFORMED;
		end else if (ovf_q) begin
			mag = '1;
			res_status = ST_SATURATED;
		end
		value_pos = {1'b0, mag};
		res_value = (neg_q && res_status != ST_MALFORMED) ? (~value_pos + 1'b1) : value_pos;
		res_fire = step && (text_byte == CH_NUL);
	end

	always_comb begin
		phase_d = phase_q;
		neg_d = neg_q;
		int_d = int_q;
		ovf_d = ovf_q;
		facc_d = facc_q;
		idx_d = idx_q;
		if (step) begin
			if (text_byte == CH_NUL) begin
				phase_d = PH_START;
				neg_d = 1'b0;
				int_d = '0;
				ovf_d = 1'b0;
				facc_d = '0;
				idx_d = '0;
			end else begin
				case (phase_q)
					PH_START, PH_AFTER_SIGN, PH_INT: begin
						if (is_digit) begin
							phase_d = PH_INT;
							if (int_sat) begin
								int_d = '1;
								ovf_d = 1'b1;
							end else begin
								int_d = int_wide[INT_BITS-1:0];
							end
						end else if (phase_q == PH_START && text_byte == CH_MINUS) begin
							neg_d = 1'b1;
							phase_d = PH_AFTER_SIGN;
						end else if (phase_q == PH_START && text_byte == CH_PLUS) begin
							phase_d = PH_AFTER_SIGN;
						end else if (phase_q == PH_INT && text_byte == CH_DOT) begin
							phase_d = PH_FRAC;
						end else begin
							phase_d = PH_BAD;
						end
					end
					PH_FRAC: begin
						if (is_digit) begin
							facc_d = facc_q + frac_term[FACC_BITS-1:0];
							if (idx_q != scale_idx_t'(SCALE_N - 1))
								idx_d = idx_q + 1'b1;
						end else begin
							phase_d = PH_BAD;
						end
					end
					default: phase_d = PH_BAD;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q <= 1'b0;
			int_q <= '0;
			ovf_q <= 1'b0;
			facc_q <= '0;
			idx_q <= '0;
		end else begin
			phase_q <= phase_d;
			neg_q <= neg_d;
			int_q <= int_d;
			ovf_q <= ovf_d;
			facc_q <= facc_d;
			idx_q <= idx_d;
		end
	end

endmodule

// ----- rtl/core/decimal_text_to_fixed_point_unit.sv -----
// channel | dir | width        | contents
// s_*     | in  | 8            | text_byte, one character per word, 0 ends the number
// m_*     | out | bytes of 35  | fixed_value (33, signed), status (2), one word per number
//
// one text byte is taken per cycle unless a held result stalls the input; it waits in the
// input register, then the parser updates its state and, for a zero byte, loads the result register
// m_tvalid rises as the result register is loaded for the zero byte
// a held result only stalls the input when the next zero byte reaches the parser
// arst_n clears both valid flags and returns the parser to the start of a number
module decimal_text_to_fixed_point_unit #(
	parameter int INT_BITS  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] text_byte
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [INT_BITS+FRAC_BITS:0] fixed_value, next 2 bits status, zero fill above
	output logic [((INT_BITS+FRAC_BITS+3+7)/8)*8-1:0] m_tdata
);
	import dtfp_pkg::*;

	localparam int OUT_BITS = INT_BITS + FRAC_BITS + 1;
	localparam int TD_BITS  = ((OUT_BITS + 2 + 7) / 8) * 8;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic                m_valid_q;
	logic [OUT_BITS-1:0] value_q;
	status_t             status_q;

	logic                advance;
	logic                res_fire;
	logic [OUT_BITS-1:0] res_value;
	status_t             res_status;

	// a non-terminating byte never needs the result register, so it always moves on
	assign advance = valid_s1 && ((byte_s1 != CH_NUL) || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	dtfp_parse #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.text_byte  (byte_s1),
		.res_fire   (res_fire),
		.res_value  (res_value),
		.res_status (res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			value_q <= res_value;
			status_q <= res_status;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{(TD_BITS-OUT_BITS-2){1'b0}}, status_q, value_q};

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import dtfp_pkg::*;

	localparam int VALUE_W     = 33;
	localparam int WORD_W      = ((VALUE_W + 2 + 7) / 8) * 8;
	localparam int TEXT_ITEMS  = 1300;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 8;
	localparam logic [VALUE_W-1:0] SAT_MAG = 33'h0_ffff_ffff;

	// where the parser stands inside one number
	typedef enum logic [2:0] {
		PH_START,
		PH_SIGNED,
		PH_INTEGER,
		PH_FRACTION,
		PH_REJECT
	} text_phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
	} number_t;

	// one directed number: its text, and the result where it is obvious
	typedef struct {
		string              text;
		bit                 typed;
		logic [VALUE_W-1:0] value;
		status_t            status;
	} text_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [7:0] text_byte
	logic               m_tvalid;
	logic               m_tready;
	logic [WORD_W-1:0]  m_tdata;   // [32:0] fixed_value, [34:33] status, zero fill above

	// predictor state for the number being parsed
	text_phase_t        txt_phase;
	bit                 txt_negative;
	logic [15:0]        int_part;
	bit                 int_saturated;
	logic [23:0]        frac_part;
	logic [23:0]        frac_weight;

	number_t            pending_numbers[$];
	int                 text_items = 0;
	int                 mismatch_count = 0;
	int                 stall_cycles = 0;
	bit                 send_calm = 1'b0;
	bit                 hold_wanted = 1'b0;

	// directed numbers: edges of the grammar, positive saturation and the error paths
	text_row_t directed_rows[8] = '{
		'{"",      1'b1, 33'h0,            ST_MALFORMED},  // terminator alone
		'{"9",     1'b1, 33'h0_0009_0000,  ST_OK},
		'{"-0",    1'b1, 33'h0,            ST_OK},         // negative zero
		'{"5.",    1'b1, 33'h0_0005_0000,  ST_OK},         // trailing dot
		'{"99999", 1'b1, SAT_MAG,          ST_SATURATED},
		'{"-.5",   1'b1, 33'h0,            ST_MALFORMED},  // dot with no integer digit
		'{"\377",  1'b1, 33'h0,            ST_MALFORMED},  // top byte value, outside grammar
		'{"-7.25", 1'b0, 33'h0,            ST_OK}
	};

	decimal_text_to_fixed_point_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// back to the start of a number, as after reset and after every result
	task automatic clear_text_state();
		txt_phase     = PH_START;
		txt_negative  = 1'b0;
		int_part      = '0;
		int_saturated = 1'b0;
		frac_part     = '0;
		frac_weight   = 24'd1677721;  // floor(2^24 / 10)
	endtask

	// integer digit, sticking at the top of the 16-bit range
	task automatic take_int_digit(input logic [7:0] c);
		logic [19:0] grown;
		grown = {4'd0, int_part} * 20'd10 + {12'd0, c - CH_ZERO};
		if (grown > 20'hffff) begin
			int_part      = 16'hffff;
			int_saturated = 1'b1;
		end else begin
			int_part = grown[15:0];
		end
	endtask

	// steps the parser by one accepted text byte; a zero byte yields the number
	task automatic absorb_text_byte(input logic [7:0] c, output bit done, output number_t num);
		bit                 is_digit;
		logic [27:0]        frac_sum;
		logic [VALUE_W-1:0] mag;
		done     = 1'b0;
		num      = '0;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_NUL) begin
			done = 1'b1;
			if (txt_phase != PH_INTEGER && txt_phase != PH_FRACTION) begin
				num.status = ST_MALFORMED;
			end else begin
				if (int_saturated) begin
					mag        = SAT_MAG;
					num.status = ST_SATURATED;
				end else begin
					mag        = {1'b0, int_part, frac_part[23:8]};
					num.status = ST_OK;
				end
				// the sign applies to the whole value, fraction included
				num.value = txt_negative ? -mag : mag;
			end
			clear_text_state();
		end else begin
			case (txt_phase)
				PH_START: begin
					if (c == CH_MINUS) begin
						txt_negative = 1'b1;
						txt_phase    = PH_SIGNED;
					end else if (c == CH_PLUS) begin
						txt_phase = PH_SIGNED;
					end else if (is_digit) begin
						take_int_digit(c);
						txt_phase = PH_INTEGER;
					end else begin
						txt_phase = PH_REJECT;
					end
				end
				PH_SIGNED: begin
					if (is_digit) begin
						take_int_digit(c);
						txt_phase = PH_INTEGER;
					end else begin
						txt_phase = PH_REJECT;
					end
				end
				PH_INTEGER: begin
					if (is_digit) take_int_digit(c);
					else if (c == CH_DOT) txt_phase = PH_FRACTION;
					else txt_phase = PH_REJECT;
				end
				PH_FRACTION: begin
					if (is_digit) begin
						// weight runs down to zero after enough digits; then digits add nothing
						frac_sum    = {4'd0, frac_part} + {4'd0, frac_weight} * 28'(c - CH_ZERO);
						frac_part   = frac_sum[23:0];
						frac_weight = frac_weight / 24'd10;
					end else begin
						txt_phase = PH_REJECT;
					end
				end
				default: txt_phase = PH_REJECT;
			endcase
		end
	endtask

	// offers one text byte after a random gap and waits for it to be taken;
	// a typed result, where given, replaces the predicted one
	task automatic send_text_byte(input logic [7:0] c, input bit typed, input number_t typed_num);
		int      gap;
		bit      done;
		number_t num;
		gap = send_calm ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		absorb_text_byte(c, done, num);
		if (done) pending_numbers.push_back(typed ? typed_num : num);
		text_items++;
		@(negedge clk);
	endtask

	// sender goes quiet until every number it sent has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_numbers.size() != 0) @(negedge clk);
	endtask

	// stimulus
	initial begin
		number_t    none;
		number_t    row_num;
		logic [7:0] word_text[$];
		int         kind;
		int         nint;
		int         pos;
		bit         paused;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		none     = '0;
		paused   = 1'b0;
		clear_text_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].text.len(); k++)
				send_text_byte(directed_rows[r].text[k], 1'b0, none);
			row_num.value  = directed_rows[r].value;
			row_num.status = directed_rows[r].status;
			send_text_byte(CH_NUL, directed_rows[r].typed, row_num);
		end

		// mostly well-formed numbers with random digits, some broken ones and noise
		while (text_items < TEXT_ITEMS) begin
			word_text.delete();
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				repeat ($urandom_range(1, 6)) word_text.push_back(8'($urandom_range(1, 255)));
			end else begin
				case ($urandom_range(0, 3))
					0: word_text.push_back(CH_MINUS);
					1: word_text.push_back(CH_PLUS);
					default: ;
				endcase
				// no integer digit, long integers that may saturate, or short ones
				nint = (kind < 11) ? 0 : (kind < 22) ? $urandom_range(5, 8) : $urandom_range(1, 4);
				repeat (nint) word_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 2) != 0) begin
					word_text.push_back(CH_DOT);
					repeat ($urandom_range(0, 9))
						word_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				// break some: a stray dot or a stray byte somewhere
				if (kind >= 22 && kind < 32) begin
					pos = $urandom_range(0, word_text.size());
					word_text.insert(pos, (kind < 27) ? CH_DOT : 8'($urandom_range(1, 255)));
				end
			end
			foreach (word_text[k]) send_text_byte(word_text[k], 1'b0, none);
			send_text_byte(CH_NUL, 1'b0, none);
			if (text_items > 300) hold_wanted = 1'b1;
			if (!paused && text_items > 650) begin
				wait_for_results();
				paused = 1'b1;
			end
		end

		wait_for_results();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off, compare against the oldest expectation
	initial begin
		int                 stall;
		bit                 calm;
		bit                 held;
		number_t            want;
		logic [VALUE_W-1:0] got_value;
		status_t            got_status;
		m_tready = 1'b0;
		calm     = 1'b0;
		held     = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 63) == 0) calm = !calm;
			// long hold-off so the parser backs up and stalls its input
			if (hold_wanted && !held) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got_value  = m_tdata[VALUE_W-1:0];
			got_status = m_tdata[VALUE_W+1:VALUE_W];
			if (pending_numbers.size() == 0) begin
				$error("unexpected word: fixed_value %h status %0d", got_value, got_status);
				mismatch_count++;
			end else begin
				want = pending_numbers.pop_front();
				if (got_value !== want.value) begin
					$error("fixed_value: expected %h, got %h", want.value, got_value);
					mismatch_count++;
				end
				if (got_status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got_status);
					mismatch_count++;
				end
			end
			@(negedge clk);
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
